// File: sv/mpm_pkg.sv
// Shared types, codes and constants of the multichannel phrase matcher.
package mpm_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int MAX_LEN_DEF  = 32;

  // Field widths fixed by the item format.
  localparam int OPCODE_W = 2;
  localparam int CHAN_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 5;
  // A phrase length or match index runs up to 32, one more than the top position.
  localparam int LEN_W    = POS_W + 1;
  // Channel slot carried through the queue, wide enough for the largest CHANNELS.
  localparam int SLOT_W   = 4;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [OPCODE_W-1:0] OP_DATA  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

  // What the back part has to do with an item.
  typedef enum logic [1:0] {
    K_NOP,
    K_DATA,
    K_WRITE,
    K_CLEAR
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic                ch_ok;
    logic [SLOT_W-1:0]   slot;
    logic [CHAN_W-1:0]   channel;
    logic [BYTE_W-1:0]   data_byte;
    logic [POS_W-1:0]    position;
    logic                last_of_phrase;
  } item_t;

endpackage

// File: sv/mpm_if.sv
// Handshake channels of the phrase matcher: requests, results and configuration.
interface mpm_req_if;
  logic                        valid;
  logic                        ready;
  logic [mpm_pkg::OPCODE_W-1:0] opcode;
  logic [mpm_pkg::CHAN_W-1:0]   channel;
  logic [mpm_pkg::BYTE_W-1:0]   data_byte;
  logic [mpm_pkg::POS_W-1:0]    position;
  logic                        last_of_phrase;

  modport source (output valid, opcode, channel, data_byte, position, last_of_phrase,
                  input ready);
  modport sink (input valid, opcode, channel, data_byte, position, last_of_phrase,
                output ready);
endinterface

interface mpm_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      phrase_matched;
  logic                      phrase_found;
  logic [mpm_pkg::CHAN_W-1:0] channel_out;

  modport source (output valid, phrase_matched, phrase_found, channel_out, input ready);
  modport sink (input valid, phrase_matched, phrase_found, channel_out, output ready);
endinterface

interface mpm_cfg_if;
  logic valid;
  logic ready;
  logic search_enable;

  modport source (output valid, search_enable, input ready);
  modport sink (input valid, search_enable, output ready);
endinterface

// File: sv/mpm_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module mpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/mpm_front.sv
// Front part: accepts request items, classifies them and queues them for the back part.
module mpm_front #(
  parameter int CHANNELS = mpm_pkg::CHANNELS_DEF,
  parameter int MAX_LEN  = mpm_pkg::MAX_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst,
  mpm_req_if.sink        req,
  output mpm_pkg::item_t q_item,
  output logic           q_valid,
  input  logic           q_pop
);

  localparam int PTR_W = (mpm_pkg::QUEUE_DEPTH > 1) ? $clog2(mpm_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(mpm_pkg::QUEUE_DEPTH + 1);

  mpm_pkg::item_t entries [mpm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  mpm_pkg::item_t   cls;
  logic             push;
  logic             pop;
  logic             ch_ok;
  logic             pos_ok;

  assign ch_ok  = int'(req.channel) < CHANNELS;
  assign pos_ok = int'(req.position) < MAX_LEN;

  always_comb begin
    cls.ch_ok          = ch_ok;
    cls.slot           = ch_ok ? mpm_pkg::SLOT_W'(req.channel) : '0;
    cls.channel        = req.channel;
    cls.data_byte      = req.data_byte;
    cls.position       = req.position;
    cls.last_of_phrase = req.last_of_phrase;
    // Items on a channel beyond CHANNELS, writes beyond MAX_LEN and unused opcodes collapse to a no-op here.
    unique case (req.opcode)
      mpm_pkg::OP_DATA:  cls.kind = ch_ok ? mpm_pkg::K_DATA : mpm_pkg::K_NOP;
      mpm_pkg::OP_WRITE: cls.kind = (ch_ok && pos_ok) ? mpm_pkg::K_WRITE : mpm_pkg::K_NOP;
      mpm_pkg::OP_CLEAR: cls.kind = ch_ok ? mpm_pkg::K_CLEAR : mpm_pkg::K_NOP;
      default:           cls.kind = mpm_pkg::K_NOP;
    endcase
  end

  assign req.ready = (count != CNT_W'(mpm_pkg::QUEUE_DEPTH));
  assign push      = req.valid && req.ready;
  assign q_valid   = (count != '0);
  assign pop       = q_pop && q_valid;
  assign q_item    = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(mpm_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(mpm_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= cls;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(mpm_pkg::QUEUE_DEPTH))
    else $error("queue fill count above its depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue fill count missed a push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 1'b1)
    else $error("queue fill count missed a pop");

endmodule

// File: sv/mpm_back.sv
// Back part: reads the phrase memory, updates the channel state and registers results.
module mpm_back #(
  parameter int CHANNELS = mpm_pkg::CHANNELS_DEF,
  parameter int MAX_LEN  = mpm_pkg::MAX_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           search_enable,
  input  mpm_pkg::item_t q_item,
  input  logic           q_valid,
  output logic           q_pop,
  mpm_rsp_if.source      rsp
);

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH = CHANNELS * MAX_LEN;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = mpm_pkg::LEN_W;

  logic [LW-1:0]       len_q     [CHANNELS];
  logic [LW-1:0]       len_next  [CHANNELS];
  logic [LW-1:0]       pos_q     [CHANNELS];
  logic [LW-1:0]       pos_next  [CHANNELS];
  logic [CHANNELS-1:0] found_q;
  logic [CHANNELS-1:0] found_next;

  logic                b_valid;
  mpm_pkg::item_t      b_item;
  logic [LW-1:0]       b_idx;
  logic                b_fire;
  logic [CH_W-1:0]     bch;
  logic [LW-1:0]       b_len;
  logic [LW-1:0]       idx_inc;
  logic                hit;
  logic                exec_matched;
  logic                exec_found;

  logic                o_valid;
  logic                o_matched;
  logic                o_found;
  logic [mpm_pkg::CHAN_W-1:0] o_ch;

  logic [CH_W-1:0]     pch;
  logic [LW-1:0]       cur_len;
  logic [LW-1:0]       cur_pos;
  logic [LW-1:0]       issue_idx;
  logic [LW-1:0]       addr_idx;
  logic [AW-1:0]       ram_addr;
  logic                ram_we;
  logic                ram_re;
  logic [mpm_pkg::BYTE_W-1:0] ram_rdata;

  assign b_fire  = b_valid && (!o_valid || rsp.ready);
  assign bch     = b_item.slot[CH_W-1:0];
  assign b_len   = len_q[bch];
  assign idx_inc = b_idx + 1'b1;
  assign hit     = (ram_rdata == b_item.data_byte);

  always_comb begin
    len_next     = len_q;
    pos_next     = pos_q;
    found_next   = found_q;
    exec_matched = 1'b0;
    if (b_fire) begin
      unique case (b_item.kind)
        mpm_pkg::K_DATA: begin
          if (search_enable && (b_len != '0)) begin
            if (hit) begin
              pos_next[bch] = idx_inc;
              if (idx_inc == b_len) begin
                found_next[bch] = 1'b1;
                exec_matched    = 1'b1;
              end
            end else begin
              pos_next[bch] = '0;
            end
          end
        end
        mpm_pkg::K_WRITE: begin
          if (b_item.last_of_phrase) begin
            len_next[bch]   = LW'(b_item.position) + 1'b1;
            pos_next[bch]   = '0;
            found_next[bch] = 1'b0;
          end
        end
        mpm_pkg::K_CLEAR: begin
          pos_next[bch]   = '0;
          found_next[bch] = 1'b0;
        end
        mpm_pkg::K_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign exec_found = b_item.ch_ok && found_next[bch];

  // The issuing item sees the state as the executing item leaves it.
  assign q_pop     = q_valid && (!b_valid || b_fire);
  assign pch       = q_item.slot[CH_W-1:0];
  assign cur_len   = len_next[pch];
  assign cur_pos   = pos_next[pch];
  assign issue_idx = (cur_pos >= cur_len) ? '0 : cur_pos;
  assign addr_idx  = (q_item.kind == mpm_pkg::K_WRITE) ? LW'(q_item.position) : issue_idx;
  assign ram_addr  = AW'(int'(q_item.slot) * MAX_LEN + int'(addr_idx));
  assign ram_we    = q_pop && (q_item.kind == mpm_pkg::K_WRITE);
  assign ram_re    = q_pop && (q_item.kind == mpm_pkg::K_DATA);

  mpm_ram #(
    .WIDTH(mpm_pkg::BYTE_W),
    .DEPTH(DEPTH)
  ) u_phrase_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_addr),
    .wdata(q_item.data_byte),
    .re   (ram_re),
    .raddr(ram_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      o_valid <= 1'b0;
      found_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        len_q[i] <= '0;
        pos_q[i] <= '0;
      end
    end else begin
      len_q   <= len_next;
      pos_q   <= pos_next;
      found_q <= found_next;
      if (q_pop) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
      if (b_fire) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_item <= q_item;
      b_idx  <= issue_idx;
    end
    if (b_fire) begin
      o_matched <= exec_matched;
      o_found   <= exec_found;
      o_ch      <= b_item.channel;
    end
  end

  assign rsp.valid          = o_valid;
  assign rsp.phrase_matched = o_matched;
  assign rsp.phrase_found   = o_found;
  assign rsp.channel_out    = o_ch;

  a_match_sets_found: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_matched) |-> o_found)
    else $error("match reported without the found flag");

  a_hold_read_data: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !b_fire) |-> !q_pop)
    else $error("item issued over a stalled stage");

  for (genvar g = 0; g < CHANNELS; g++) begin : g_idx_chk
    a_idx_in_phrase: assert property (@(posedge clk) disable iff (rst)
      pos_q[g] <= len_q[g])
      else $error("match index beyond the phrase length");
  end

endmodule

// File: sv/multichannel_phrase_matcher.sv
// Top level of the multichannel phrase matcher.
// The req channel carries one item per handshake: an opcode, a channel, a byte, a
// phrase position and a last flag. Data items are matched against the channel's
// phrase, write items store a phrase byte, clear items reset the channel's index
// and found flag. Every accepted item gives exactly one item on rsp, in order,
// with the matched pulse, the channel's found flag and the channel number.
// The cfg channel writes search_enable; it is always ready. The user is to write it only
// while no item is in flight; the block itself does not enforce this.
// Without a stall, an accepted item enters the input queue at the accepting edge, is issued
// with the registered phrase memory read into the execute stage and lands in the output
// register, where rsp valid rises. One item per cycle is sustained while rsp stays ready,
// set by the single phrase memory port used once per item; the channel state is forwarded
// so that an item may follow on the same channel.
// When rsp stalls the output register holds, the execute stage waits and the
// two-entry input queue fills before req drops ready.
// Reset clears every phrase length, match index, found flag and search_enable at
// once; the phrase memory is not cleared and needs no sweep.
module multichannel_phrase_matcher #(
  parameter int CHANNELS = mpm_pkg::CHANNELS_DEF,
  parameter int MAX_LEN  = mpm_pkg::MAX_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst,
  mpm_req_if.sink   req,
  mpm_rsp_if.source rsp,
  mpm_cfg_if.sink   cfg
);

  logic           search_enable;
  mpm_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_enable <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      search_enable <= cfg.search_enable;
    end
  end

  mpm_front #(
    .CHANNELS(CHANNELS),
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .q_item (q_item),
    .q_valid(q_valid),
    .q_pop  (q_pop)
  );

  mpm_back #(
    .CHANNELS(CHANNELS),
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .search_enable(search_enable),
    .q_item       (q_item),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .rsp          (rsp)
  );

endmodule

// File: sim/tb_multichannel_phrase_matcher.sv
`timescale 1ns / 1ps
// Self-checking testbench of the multichannel phrase matcher with its own channel state model.
module tb_multichannel_phrase_matcher;

  localparam int CHANNELS = mpm_pkg::CHANNELS_DEF;
  localparam int MAX_LEN = mpm_pkg::MAX_LEN_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam logic [mpm_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [mpm_pkg::OPCODE_W-1:0] opcode;
    logic [mpm_pkg::CHAN_W-1:0]   channel;
    logic [mpm_pkg::BYTE_W-1:0]   data_byte;
    logic [mpm_pkg::POS_W-1:0]    position;
    logic                         last_of_phrase;
  } req_fields_t;

  typedef struct packed {
    logic                       phrase_matched;
    logic                       phrase_found;
    logic [mpm_pkg::CHAN_W-1:0] channel_out;
  } rsp_fields_t;

  // Phrases, match indexes and found flags of every channel, and the results still owed.
  class channel_phrase_state;
    bit [mpm_pkg::BYTE_W-1:0] phrase_bytes [CHANNELS][MAX_LEN];
    int unsigned     phrase_len [CHANNELS];
    int unsigned     match_idx [CHANNELS];
    bit              found_flag [CHANNELS];
    bit              search_on;
    rsp_fields_t     due_results [$];
    int unsigned     failures;

    function void note_item(req_fields_t it);
      rsp_fields_t r;
      int unsigned ch;
      int unsigned idx;
      ch = it.channel;
      r = '0;
      r.channel_out = it.channel;
      case (it.opcode)
        mpm_pkg::OP_DATA: begin
          if (search_on && phrase_len[ch] != 0) begin
            idx = match_idx[ch];
            // A channel that completed its phrase starts again from the first byte.
            if (idx >= phrase_len[ch]) idx = 0;
            if (phrase_bytes[ch][idx] == it.data_byte) begin
              idx++;
              match_idx[ch] = idx;
              if (idx == phrase_len[ch]) begin
                found_flag[ch] = 1'b1;
                r.phrase_matched = 1'b1;
              end
            end else begin
              match_idx[ch] = 0;
            end
          end
        end
        mpm_pkg::OP_WRITE: begin
          phrase_bytes[ch][it.position] = it.data_byte;
          if (it.last_of_phrase) begin
            phrase_len[ch] = it.position + 1;
            match_idx[ch] = 0;
            found_flag[ch] = 1'b0;
          end
        end
        mpm_pkg::OP_CLEAR: begin
          match_idx[ch] = 0;
          found_flag[ch] = 1'b0;
        end
        default: ;
      endcase
      r.phrase_found = found_flag[ch];
      due_results.push_back(r);
    endfunction

    function void flag_mismatch(string field, logic [mpm_pkg::CHAN_W-1:0] ch,
                                logic [1:0] want, logic [1:0] got);
      $display("%0t: channel %0d %s expected %0d, got %0d", $time, ch, field, want, got);
      failures++;
    endfunction

    function void check_result(rsp_fields_t got);
      rsp_fields_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result on channel %0d with none expected (matched %0b, found %0b)",
                 $time, got.channel_out, got.phrase_matched, got.phrase_found);
        failures++;
        return;
      end
      want = due_results.pop_front();
      if (got.channel_out !== want.channel_out)
        flag_mismatch("channel_out", want.channel_out, want.channel_out, got.channel_out);
      if (got.phrase_matched !== want.phrase_matched)
        flag_mismatch("phrase_matched", want.channel_out, 2'(want.phrase_matched),
                      2'(got.phrase_matched));
      if (got.phrase_found !== want.phrase_found)
        flag_mismatch("phrase_found", want.channel_out, 2'(want.phrase_found),
                      2'(got.phrase_found));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  mpm_req_if req_bus ();
  mpm_rsp_if rsp_bus ();
  mpm_cfg_if cfg_bus ();

  multichannel_phrase_matcher i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus),
    .cfg (cfg_bus)
  );

  always #5 clk = ~clk;

  channel_phrase_state tracker;

  // What the stimulus knows of each channel, so that it can build matching byte runs.
  bit [mpm_pkg::BYTE_W-1:0] gen_bytes [CHANNELS][MAX_LEN];
  bit [MAX_LEN-1:0] gen_written [CHANNELS];
  int unsigned      gen_len [CHANNELS];
  int unsigned      items_issued = 0;
  int unsigned      src_idle_pct;
  int unsigned      snk_idle_pct;
  bit               hold_armed = 1'b0;
  bit               hold_taken = 1'b0;
  int unsigned      hold_left = 0;
  int unsigned      cycles = 0;

  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready)
      tracker.check_result('{rsp_bus.phrase_matched, rsp_bus.phrase_found,
                             rsp_bus.channel_out});
  end

  // Result side: random stalls, and one long hold-off once it is armed.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      rsp_bus.ready = 1'b0;
      hold_left--;
    end else if (hold_armed && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      rsp_bus.ready = 1'b0;
    end else begin
      rsp_bus.ready = ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("multichannel_phrase_matcher regression: fail");
    $finish;
  end

  function automatic logic [mpm_pkg::CHAN_W-1:0] rand_chan();
    int unsigned pick;
    pick = $urandom_range(CHANNELS - 1);
    return pick[mpm_pkg::CHAN_W-1:0];
  endfunction

  task automatic send_item(input req_fields_t it);
    bit sent;
    sent = 1'b0;
    while (!sent) begin
      @(negedge clk);
      if ($urandom_range(99) < src_idle_pct) begin
        req_bus.valid = 1'b0;
      end else begin
        req_bus.valid = 1'b1;
        req_bus.opcode = it.opcode;
        req_bus.channel = it.channel;
        req_bus.data_byte = it.data_byte;
        req_bus.position = it.position;
        req_bus.last_of_phrase = it.last_of_phrase;
        @(posedge clk);
        while (!req_bus.ready) @(posedge clk);
        sent = 1'b1;
      end
    end
    tracker.note_item(it);
  endtask

  // A phrase is only closed once every byte below its end has been written, so that no
  // compare ever reads an unwritten phrase byte.
  task automatic issue(input logic [mpm_pkg::OPCODE_W-1:0] op,
                       input logic [mpm_pkg::CHAN_W-1:0] ch,
                       input logic [mpm_pkg::BYTE_W-1:0] b,
                       input logic [mpm_pkg::POS_W-1:0] pos,
                       input logic last);
    req_fields_t      it;
    logic [MAX_LEN-1:0] one_hot;
    logic [MAX_LEN-1:0] have;
    logic [MAX_LEN-1:0] need;
    if (op == mpm_pkg::OP_WRITE) begin
      one_hot = 1;
      one_hot = one_hot << pos;
      have = gen_written[ch] | one_hot;
      need = (one_hot << 1) - 1;
      if ((have & need) != need) last = 1'b0;
      gen_written[ch] = have;
      gen_bytes[ch][pos] = b;
      if (last) gen_len[ch] = pos + 1;
    end
    if (op != OP_UNUSED) items_issued++;
    it = '{op, ch, b, pos, last};
    send_item(it);
  endtask

  task automatic feed(input logic [mpm_pkg::CHAN_W-1:0] ch,
                      input logic [mpm_pkg::BYTE_W-1:0] b);
    issue(mpm_pkg::OP_DATA, ch, b, 5'($urandom), 1'($urandom));
  endtask

  task automatic write_enable(input logic value);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.search_enable = value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    tracker.search_on = value;
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    req_bus.valid = 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
  endtask

  task automatic new_phrase(input logic [mpm_pkg::CHAN_W-1:0] ch);
    int n;
    int k;
    bit narrow;
    n = ($urandom_range(9) == 0) ? $urandom_range(MAX_LEN, 7) : $urandom_range(6, 1);
    narrow = 1'($urandom_range(1));
    for (k = 0; k < n; k++)
      issue(mpm_pkg::OP_WRITE, ch, narrow ? 8'h41 + 8'($urandom_range(1)) : 8'($urandom),
            5'(k), k == n - 1);
  endtask

  // Whole phrases and broken-off prefixes on one channel, with stray bytes on any channel.
  task automatic feed_run(input logic [mpm_pkg::CHAN_W-1:0] ch);
    int cut;
    int k;
    repeat ($urandom_range(3, 1)) begin
      if (gen_len[ch] == 0 || $urandom_range(99) < 15) feed(rand_chan(), 8'($urandom));
      if (gen_len[ch] == 0 || $urandom_range(99) < 70) cut = gen_len[ch];
      else cut = $urandom_range(gen_len[ch] - 1);
      for (k = 0; k < cut; k++) feed(ch, gen_bytes[ch][k]);
      if (cut < gen_len[ch]) feed(ch, gen_bytes[ch][cut] ^ 8'(1 << $urandom_range(7)));
    end
  endtask

  task automatic random_items(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    logic [mpm_pkg::CHAN_W-1:0] ch;
    stop_at = items_issued + count;
    while (items_issued < stop_at) begin
      pick = $urandom_range(99);
      ch = rand_chan();
      if (pick < 12) begin
        new_phrase(ch);
      end else if (pick < 62) begin
        feed_run(ch);
      end else if (pick < 72) begin
        feed(ch, 8'($urandom));
      end else if (pick < 80) begin
        issue(mpm_pkg::OP_WRITE, ch, 8'($urandom), 5'($urandom), 1'($urandom));
      end else if (pick < 88) begin
        issue(mpm_pkg::OP_CLEAR, ch, 8'($urandom), 5'($urandom), 1'($urandom));
      end else if (pick < 93) begin
        issue(OP_UNUSED, ch, 8'($urandom), 5'($urandom), 1'($urandom));
      end else begin
        repeat ($urandom_range(8, 2)) feed(ch, 8'h41 + 8'($urandom_range(1)));
      end
    end
  endtask

  task automatic directed_items();
    // Search is still off from reset: the phrase is stored but data bytes do nothing.
    issue(mpm_pkg::OP_WRITE, 2'd0, 8'h00, 5'd0, 1'b0);
    issue(mpm_pkg::OP_WRITE, 2'd0, 8'hFF, 5'd1, 1'b1);
    feed(2'd0, 8'h00);
    feed(2'd0, 8'hFF);
    issue(OP_UNUSED, 2'd1, 8'hFF, 5'd31, 1'b1);
    drain();
    write_enable(1'b1);
    feed(2'd0, 8'h00);
    feed(2'd0, 8'hFF);
    // Restart after a completed phrase, then a miss that is not compared again.
    feed(2'd0, 8'h00);
    feed(2'd0, 8'h00);
    feed(2'd0, 8'hFF);
    feed(2'd1, 8'h55);
    issue(mpm_pkg::OP_WRITE, 2'd3, 8'hAA, 5'd31, 1'b0);
    issue(mpm_pkg::OP_WRITE, 2'd2, 8'hFF, 5'd0, 1'b1);
    feed(2'd2, 8'hFF);
    feed(2'd2, 8'hFF);
    issue(mpm_pkg::OP_CLEAR, 2'd2, 8'hFF, 5'd31, 1'b1);
    issue(OP_UNUSED, 2'd0, 8'h00, 5'd0, 1'b0);
    issue(mpm_pkg::OP_WRITE, 2'd0, 8'hFF, 5'd1, 1'b1);
  endtask

  initial begin
    tracker = new;
    rst = 1'b1;
    req_bus.valid = 1'b0;
    req_bus.opcode = mpm_pkg::OP_DATA;
    req_bus.channel = '0;
    req_bus.data_byte = '0;
    req_bus.position = '0;
    req_bus.last_of_phrase = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.search_enable = 1'b0;
    rsp_bus.ready = 1'b0;
    src_idle_pct = 20;
    snk_idle_pct = 57;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_items();
    random_items(250);
    drain();

    src_idle_pct = 57;
    snk_idle_pct = 20;
    write_enable(1'b0);
    random_items(60);
    drain();
    write_enable(1'b1);
    random_items(200);
    drain();

    // No idling; the result side holds off for a long stretch so the input stalls.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_armed = 1'b1;
    random_items(200);
    drain();
    repeat (8) @(posedge clk);

    if (tracker.failures == 0 && tracker.due_results.size() == 0) begin
      $display("multichannel_phrase_matcher regression: pass");
    end else begin
      $display("multichannel_phrase_matcher regression: fail");
    end
    $finish;
  end

endmodule
